/* design/cep_pkg.sv */
// ----------------------------------------------------------------------------
// cep_pkg: shared types, constants and tables of the cosine eased pose sequencer
// Widths, codes, the element control bundle and the elaboration-time tables
// (raised-cosine weights and the reset target pose).
// ----------------------------------------------------------------------------
package cep_pkg;

  // sizing
  localparam int POSE_ELEMENTS = 16;
  localparam int EASE_ENTRIES  = 1024;
  localparam int FRACTION_BITS = 29;

  // field widths
  localparam int ACTION_W   = 2;
  localparam int ELEM_IDX_W = 4;
  localparam int VALUE_W    = 32;
  localparam int PERIOD_W   = 20;
  localparam int PHASE_W    = 2;
  localparam int DUR_W      = 26;
  localparam int OFFSET_W   = 31;
  localparam int ELAPSED_W  = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // derived widths
  localparam int PIDX_W      = (POSE_ELEMENTS > 1) ? $clog2(POSE_ELEMENTS) : 1;
  localparam int EIDX_W      = $clog2(EASE_ENTRIES);
  localparam int WEIGHT_FRAC = 16;
  localparam int WEIGHT_W    = WEIGHT_FRAC + 1;
  localparam int WEIGHT_ONE  = 1 << WEIGHT_FRAC;

  localparam int SECOND_ELEMENT = 13;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD_START  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_TARGET = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK        = 2'd2;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_MOVE_A = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HOLD   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_MOVE_B = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd3;

  // configuration reset values
  localparam logic [DUR_W-1:0]           MOVE_A_RST = 26'd3000000;
  localparam logic [DUR_W-1:0]           HOLD_RST   = 26'd5000000;
  localparam logic [DUR_W-1:0]           MOVE_B_RST = 26'd2000000;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 31'sd53687091;

  // per-element control carried down the blend pipeline
  typedef struct packed {
    logic [PIDX_W-1:0]   idx;
    logic                last;
    logic [PHASE_W-1:0]  phase;
    logic                grasp;
    logic [WEIGHT_W-1:0] weight;
  } elem_ctl_t;

  typedef logic [WEIGHT_W-1:0]       ease_tbl_t [EASE_ENTRIES];
  typedef logic signed [VALUE_W-1:0] pose_tbl_t [POSE_ELEMENTS];

  // reference pose in Q2.29
  localparam int REF_POSE_Q29 [16] = '{
    2485744, -6634379, -536824154, 0,
    536711030, -12831499, 2643800, 0,
    -12863053, -536676545, 6572993, 0,
    309923792, 62102312, 59923205, 536870912
  };

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned TAYLOR_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  // sin^2 weights from a fixed-point Taylor series, rounded to Q1.16
  function automatic ease_tbl_t build_ease();
    ease_tbl_t         tbl;
    longint unsigned   theta;
    longint unsigned   t2;
    longint unsigned   term;
    longint unsigned   su;
    longint unsigned   sq;
    longint unsigned   w;
    longint            s;
    for (int k = 0; k < EASE_ENTRIES; k++) begin
      theta = (HALF_PI_Q30 * 64'(k)) / 64'(EASE_ENTRIES - 1);
      t2    = (theta * theta) >> 30;
      term  = theta;
      s     = longint'(theta);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * t2) >> 30) / TAYLOR_DIV[n];
        if ((n % 2) == 1) s = s - longint'(term);
        else              s = s + longint'(term);
      end
      if (s < 0) s = 0;
      if (s > longint'(Q30_ONE)) s = longint'(Q30_ONE);
      su = 64'(s);
      sq = (su * su) >> 30;
      w  = (sq + 64'd8192) >> 14;
      if (w > 64'(WEIGHT_ONE)) w = 64'(WEIGHT_ONE);
      tbl[k] = WEIGHT_W'(w);
    end
    tbl[0]                = '0;
    tbl[EASE_ENTRIES - 1] = WEIGHT_W'(WEIGHT_ONE);
    return tbl;
  endfunction

  // reference pose rescaled to FRACTION_BITS and saturated to 32 bits
  function automatic pose_tbl_t build_ref_pose();
    pose_tbl_t tbl;
    longint    v;
    int        sh;
    for (int i = 0; i < POSE_ELEMENTS; i++) begin
      v = longint'(REF_POSE_Q29[i]);
      if (FRACTION_BITS >= 29) begin
        sh = FRACTION_BITS - 29;
        v  = v <<< sh;
      end else begin
        sh = 29 - FRACTION_BITS;
        v  = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      end
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      tbl[i] = VALUE_W'(v);
    end
    return tbl;
  endfunction

endpackage

/* design/cep_if.sv */
// ----------------------------------------------------------------------------
// cep_if: request channels of the cosine eased pose sequencer
// Command channel (loads and ticks) and pose element channel, valid/ready.
// ----------------------------------------------------------------------------
interface cep_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [cep_pkg::ACTION_W-1:0]         action;
  logic [cep_pkg::ELEM_IDX_W-1:0]       element_index;
  logic signed [cep_pkg::VALUE_W-1:0]   element_value;
  logic [cep_pkg::PERIOD_W-1:0]         period_us;

  modport source (output valid, action, element_index, element_value, period_us,
                  input ready);
  modport sink   (input valid, action, element_index, element_value, period_us,
                  output ready);
endinterface

interface cep_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [cep_pkg::ELEM_IDX_W-1:0]       pose_index;
  logic signed [cep_pkg::VALUE_W-1:0]   pose_value;
  logic [cep_pkg::PHASE_W-1:0]          phase;
  logic                                 grasp_request;
  logic                                 last;

  modport source (output valid, pose_index, pose_value, phase, grasp_request, last,
                  input ready);
  modport sink   (input valid, pose_index, pose_value, phase, grasp_request, last,
                  output ready);
endinterface

/* design/cep_pose_store.sv */
// ----------------------------------------------------------------------------
// cep_pose_store: start and target pose memories
// Single write port, one registered read of both poses per cycle; entries
// never written read back as their reset value through per-entry valid bits.
// ----------------------------------------------------------------------------
module cep_pose_store (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic                                 wr_target,
  input  logic [cep_pkg::PIDX_W-1:0]           wr_idx,
  input  logic signed [cep_pkg::VALUE_W-1:0]   wr_data,
  input  logic                                 rd_en,
  input  logic [cep_pkg::PIDX_W-1:0]           rd_idx,
  output logic signed [cep_pkg::VALUE_W-1:0]   rd_start,
  output logic signed [cep_pkg::VALUE_W-1:0]   rd_target
);

  localparam cep_pkg::pose_tbl_t TARGET_RST = cep_pkg::build_ref_pose();

  logic signed [cep_pkg::VALUE_W-1:0] start_mem  [cep_pkg::POSE_ELEMENTS];
  logic signed [cep_pkg::VALUE_W-1:0] target_mem [cep_pkg::POSE_ELEMENTS];
  logic [cep_pkg::POSE_ELEMENTS-1:0]  start_vld;
  logic [cep_pkg::POSE_ELEMENTS-1:0]  target_vld;

  logic signed [cep_pkg::VALUE_W-1:0] start_q;
  logic signed [cep_pkg::VALUE_W-1:0] target_q;
  logic                               start_q_vld;
  logic                               target_q_vld;
  logic [cep_pkg::PIDX_W-1:0]         idx_q;

  always_ff @(posedge clk) begin
    if (wr_en && !wr_target) start_mem[wr_idx] <= wr_data;
    if (wr_en && wr_target)  target_mem[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_vld  <= '0;
      target_vld <= '0;
    end else if (wr_en) begin
      if (wr_target) target_vld[wr_idx] <= 1'b1;
      else           start_vld[wr_idx]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      start_q      <= start_mem[rd_idx];
      target_q     <= target_mem[rd_idx];
      start_q_vld  <= start_vld[rd_idx];
      target_q_vld <= target_vld[rd_idx];
      idx_q        <= rd_idx;
    end
  end

  // unwritten entries: start pose zero, target pose the reference pose
  assign rd_start  = start_q_vld  ? start_q  : '0;
  assign rd_target = target_q_vld ? target_q : TARGET_RST[idx_q];

endmodule

/* design/cep_ease_div.sv */
// ----------------------------------------------------------------------------
// cep_ease_div: easing table index divider
// Restoring division, one quotient bit per cycle:
// idx = round(e*(EASE_ENTRIES-1)/d) for e < d, else the last table entry.
// ----------------------------------------------------------------------------
module cep_ease_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cep_pkg::ELAPSED_W-1:0]     num_e,
  input  logic [cep_pkg::DUR_W-1:0]         den,
  output logic                              done,
  output logic [cep_pkg::EIDX_W-1:0]        quo
);

  localparam int NW = cep_pkg::DUR_W + cep_pkg::EIDX_W + 1;
  localparam int RW = cep_pkg::DUR_W + 1;
  localparam int CW = $clog2(cep_pkg::EIDX_W + 1);

  logic [NW-1:0]             n_full;
  logic                      e_ge_d;
  logic [RW-1:0]             rem;
  logic [cep_pkg::EIDX_W-1:0] num_lo;
  logic [CW-1:0]             cnt;
  logic                      busy;
  logic [RW-1:0]             trial;
  logic                      fits;

  // numerator with rounding bias; only used when e < d, so e fits DUR_W bits
  assign n_full = NW'(num_e[cep_pkg::DUR_W-1:0]) * NW'(cep_pkg::EASE_ENTRIES - 1)
                + NW'(den >> 1);
  assign e_ge_d = num_e >= cep_pkg::ELAPSED_W'(den);
  assign trial  = {rem[RW-2:0], num_lo[cep_pkg::EIDX_W-1]};
  assign fits   = trial >= RW'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (e_ge_d) begin
          quo  <= cep_pkg::EIDX_W'(cep_pkg::EASE_ENTRIES - 1);
          done <= 1'b1;
        end else begin
          rem    <= RW'(n_full >> cep_pkg::EIDX_W);
          num_lo <= n_full[cep_pkg::EIDX_W-1:0];
          cnt    <= CW'(cep_pkg::EIDX_W);
          busy   <= 1'b1;
        end
      end else if (busy) begin
        rem    <= fits ? (trial - RW'(den)) : trial;
        quo    <= {quo[cep_pkg::EIDX_W-2:0], fits};
        num_lo <= num_lo << 1;
        cnt    <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // the partial remainder always stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < RW'(den)))
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

  assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == CW'(1)) |=> (done && !busy))
    else $error("divider did not finish after its last step");

endmodule

/* design/cep_blend.sv */
// ----------------------------------------------------------------------------
// cep_blend: pose element blend pipeline
// Three stages: endpoint select and difference, weight multiply,
// rounding add into the output register. All stages advance on en.
// ----------------------------------------------------------------------------
module cep_blend (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  cep_pkg::elem_ctl_t                   in_ctl,
  input  logic signed [cep_pkg::VALUE_W-1:0]   start_val,
  input  logic signed [cep_pkg::VALUE_W-1:0]   target_val,
  input  logic signed [cep_pkg::OFFSET_W-1:0]  offset,
  output logic                                 out_valid,
  output cep_pkg::elem_ctl_t                   out_ctl,
  output logic signed [cep_pkg::VALUE_W-1:0]   out_val
);

  localparam int VW     = cep_pkg::VALUE_W;
  localparam int DW     = VW + 1;
  localparam int PROD_W = DW + cep_pkg::WEIGHT_W + 1;
  localparam int ROUND_HALF = 1 << (cep_pkg::WEIGHT_FRAC - 1);

  // stage 2: endpoints
  logic signed [DW-1:0] lowered;
  logic signed [VW-1:0] second;
  logic signed [VW-1:0] a_n;
  logic signed [VW-1:0] b_n;
  logic signed [DW-1:0] diff_n;

  logic                 v2;
  cep_pkg::elem_ctl_t   ctl2;
  logic signed [VW-1:0] a2;
  logic signed [DW-1:0] diff2;

  // stage 3: product
  logic signed [PROD_W-1:0] prod_n;
  logic                     v3;
  cep_pkg::elem_ctl_t       ctl3;
  logic signed [VW-1:0]     a3;
  logic signed [PROD_W-1:0] prod3;

  // stage 4: rounding
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] step;

  assign lowered = {target_val[VW-1], target_val}
                 - {{(DW - cep_pkg::OFFSET_W){offset[cep_pkg::OFFSET_W-1]}}, offset};

  always_comb begin
    if (lowered[DW-1] != lowered[DW-2]) begin
      second = lowered[DW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      second = lowered[VW-1:0];
    end
  end

  assign a_n = (in_ctl.phase == cep_pkg::PH_MOVE_A) ? start_val : target_val;
  assign b_n = ((in_ctl.phase == cep_pkg::PH_MOVE_B) &&
                (32'(in_ctl.idx) == cep_pkg::SECOND_ELEMENT)) ? second : target_val;
  assign diff_n = {b_n[VW-1], b_n} - {a_n[VW-1], a_n};

  assign prod_n = diff2 * $signed({1'b0, ctl2.weight});

  assign rnd  = prod3 + $signed(PROD_W'(ROUND_HALF));
  assign step = rnd >>> cep_pkg::WEIGHT_FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2        <= in_valid;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2    <= in_ctl;
      a2      <= a_n;
      diff2   <= diff_n;
      ctl3    <= ctl2;
      a3      <= a2;
      prod3   <= prod_n;
      out_ctl <= ctl3;
      out_val <= a3 + step[VW-1:0];
    end
  end

endmodule

/* design/cosine_eased_pose_sequencer.sv */
// ----------------------------------------------------------------------------
// cosine_eased_pose_sequencer: raised-cosine three-phase pose trajectory
// Loads write start or target pose elements; each tick advances the timer
// and streams the 16 commanded pose elements.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  -------  ---  ------------  ---------------------------------------------
//  cmd      in   valid/ready   action, element_index, element_value, period_us
//  pose     out  valid/ready   pose_index, pose_value, phase, grasp_request, last
//  cfg      in   cfg_we        cfg_index, cfg_data (write only)
//
//  a load or an unused action is taken without leaving the idle state; a
//  tick goes in order: on accept the period is added, the eval state picks
//  the phase, the divide state waits on the restoring divider (one quotient
//  bit per cycle, no steps when the elapsed time is not below the duration),
//  then one element per cycle while pose is ready out of the single read port
//  of the pose store, through the registered read and the blend pipeline;
//  the next request is taken as soon as the last element read has been issued
//  reset is synchronous; the pose memories need no clearing pass, valid
//  bits return the reset pose for entries not yet loaded
//  a stall on pose freezes the whole element pipeline, reads included
//
module cosine_eased_pose_sequencer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cep_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cep_pkg::CFG_DATA_W-1:0]       cfg_data,
  cep_in_if.sink                               cmd,
  cep_out_if.source                            pose
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EVAL   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_STREAM = 4'b1000
  } state_t;

  localparam logic [cep_pkg::ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [cep_pkg::PIDX_W-1:0] LAST_IDX =
    cep_pkg::PIDX_W'(cep_pkg::POSE_ELEMENTS - 1);
  localparam cep_pkg::ease_tbl_t EASE_ROM = cep_pkg::build_ease();

  // configuration registers
  logic [cep_pkg::DUR_W-1:0]           move_a;
  logic [cep_pkg::DUR_W-1:0]           hold;
  logic [cep_pkg::DUR_W-1:0]           move_b;
  logic signed [cep_pkg::OFFSET_W-1:0] offset;

  // sequencer state
  state_t                          state;
  logic [cep_pkg::ELAPSED_W-1:0]   elapsed;
  logic                            reached;      // target reached: hold, then second move
  logic                            grasp_sent;
  logic [cep_pkg::ELAPSED_W-1:0]   tick_e;       // saturated elapsed time of this tick
  logic [cep_pkg::PHASE_W-1:0]     tick_phase;
  logic                            tick_grasp;
  logic [cep_pkg::PIDX_W-1:0]      s_cnt;

  // divider operands and result
  logic                            div_start;
  logic [cep_pkg::ELAPSED_W-1:0]   div_e;
  logic [cep_pkg::DUR_W-1:0]       div_d;
  logic                            div_done;
  logic [cep_pkg::EIDX_W-1:0]      div_quo;
  logic [cep_pkg::WEIGHT_W-1:0]    weight;

  // handshake and pipeline control
  logic                            accept;
  logic                            is_load;
  logic                            in_range;
  logic                            en;
  logic                            issue;
  logic [cep_pkg::ELAPSED_W:0]     sum;

  // element pipeline
  logic                               s1_v;
  cep_pkg::elem_ctl_t                 s1_ctl;
  cep_pkg::elem_ctl_t                 issue_ctl;
  logic signed [cep_pkg::VALUE_W-1:0] rd_start;
  logic signed [cep_pkg::VALUE_W-1:0] rd_target;
  cep_pkg::elem_ctl_t                 b_ctl;
  logic signed [cep_pkg::VALUE_W-1:0] b_val;
  logic                               b_valid;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign is_load   = (cmd.action == cep_pkg::ACT_LOAD_START) ||
                     (cmd.action == cep_pkg::ACT_LOAD_TARGET);
  assign in_range  = {1'b0, cmd.element_index} <
                     (cep_pkg::ELEM_IDX_W + 1)'(cep_pkg::POSE_ELEMENTS);

  // timer advance with saturation
  assign sum = {1'b0, elapsed} + (cep_pkg::ELAPSED_W + 1)'(cmd.period_us);

  // the pipeline moves whenever the output register is free or drains
  assign en    = !pose.valid || pose.ready;
  assign issue = (state == ST_STREAM) && en;

  always_comb begin
    issue_ctl.idx    = s_cnt;
    issue_ctl.last   = (s_cnt == LAST_IDX);
    issue_ctl.phase  = tick_phase;
    issue_ctl.grasp  = tick_grasp;
    issue_ctl.weight = weight;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      move_a <= cep_pkg::MOVE_A_RST;
      hold   <= cep_pkg::HOLD_RST;
      move_b <= cep_pkg::MOVE_B_RST;
      offset <= cep_pkg::OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cep_pkg::CFG_MOVE_A: move_a <= cfg_data[cep_pkg::DUR_W-1:0];
        cep_pkg::CFG_HOLD:   hold   <= cfg_data[cep_pkg::DUR_W-1:0];
        cep_pkg::CFG_MOVE_B: move_b <= cfg_data[cep_pkg::DUR_W-1:0];
        cep_pkg::CFG_OFFSET: offset <= $signed(cfg_data[cep_pkg::OFFSET_W-1:0]);
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      elapsed    <= '0;
      reached    <= 1'b0;
      grasp_sent <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_load) begin
              // every load restarts the trajectory
              elapsed    <= '0;
              reached    <= 1'b0;
              grasp_sent <= 1'b0;
            end else if (cmd.action == cep_pkg::ACT_TICK) begin
              tick_e <= sum[cep_pkg::ELAPSED_W] ? ELAPSED_MAX
                                                : sum[cep_pkg::ELAPSED_W-1:0];
              state  <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          div_start  <= 1'b1;
          tick_grasp <= 1'b0;
          state      <= ST_DIV;
          if (!reached) begin
            // first move: blend start to target
            tick_phase <= cep_pkg::PH_MOVE_A;
            div_e      <= tick_e;
            div_d      <= move_a;
            if (tick_e >= cep_pkg::ELAPSED_W'(move_a)) begin
              reached <= 1'b1;
              elapsed <= '0;
            end else begin
              elapsed <= tick_e;
            end
          end else if (tick_e < cep_pkg::ELAPSED_W'(hold)) begin
            // hold at target, grasp request on the first hold tick
            tick_phase <= cep_pkg::PH_HOLD;
            tick_grasp <= !grasp_sent;
            grasp_sent <= 1'b1;
            div_e      <= '0;
            div_d      <= '0;
            elapsed    <= tick_e;
          end else begin
            // second move: blend target to target with element SECOND_ELEMENT lowered
            tick_phase <= cep_pkg::PH_MOVE_B;
            div_e      <= tick_e - cep_pkg::ELAPSED_W'(hold);
            div_d      <= move_b;
            elapsed    <= tick_e;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            s_cnt <= '0;
            state <= ST_STREAM;
          end
        end
        ST_STREAM: begin
          if (issue) begin
            s_cnt <= s_cnt + 1'b1;
            if (s_cnt == LAST_IDX) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // easing weight lookup, registered read of the quotient
  always_ff @(posedge clk) begin
    if (div_done) weight <= EASE_ROM[div_quo];
  end

  // stage 1 control, aligned with the registered pose read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) s1_ctl <= issue_ctl;
  end

  cep_ease_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_e  (div_e),
    .den    (div_d),
    .done   (div_done),
    .quo    (div_quo)
  );

  // loads are only taken while no element read is pending, so a write
  // never races a read of the same entry
  cep_pose_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept && is_load && in_range),
    .wr_target (cmd.action == cep_pkg::ACT_LOAD_TARGET),
    .wr_idx    (cmd.element_index[cep_pkg::PIDX_W-1:0]),
    .wr_data   (cmd.element_value),
    .rd_en     (issue),
    .rd_idx    (s_cnt),
    .rd_start  (rd_start),
    .rd_target (rd_target)
  );

  cep_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s1_v),
    .in_ctl     (s1_ctl),
    .start_val  (rd_start),
    .target_val (rd_target),
    .offset     (offset),
    .out_valid  (b_valid),
    .out_ctl    (b_ctl),
    .out_val    (b_val)
  );

  assign pose.valid         = b_valid;
  assign pose.pose_index    = cep_pkg::ELEM_IDX_W'(b_ctl.idx);
  assign pose.pose_value    = b_val;
  assign pose.phase         = b_ctl.phase;
  assign pose.grasp_request = b_ctl.grasp;
  assign pose.last          = b_ctl.last;

  // divider results only arrive while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider result outside divide state");

  // an accepted tick always goes on to phase selection
  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.action == cep_pkg::ACT_TICK) |=> (state == ST_EVAL))
    else $error("tick not evaluated");

  // the end marker sits on the last pose element
  assert property (@(posedge clk) disable iff (rst)
    (pose.valid && pose.last) |->
      (pose.pose_index == cep_pkg::ELEM_IDX_W'(cep_pkg::POSE_ELEMENTS - 1)))
    else $error("last flag on wrong element");

  // a grasp request only comes with the hold phase
  assert property (@(posedge clk) disable iff (rst)
    (pose.valid && pose.grasp_request) |-> (pose.phase == cep_pkg::PH_HOLD))
    else $error("grasp request outside hold");

endmodule
